>>> rtl/core/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg
// Shared widths, register indexes and result codes for the streaming
// substring search.
// ----------------------------------------------------------------------------
package sss_pkg;

	localparam int TEXT_W        = 8;
	localparam int STATUS_W      = 3;
	localparam int MATCH_POS_W   = 16;
	localparam int PAT_BYTES     = 16;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_IDX_W     = 2;
	localparam int PAT_LEN_REG_W = 5;

	localparam int MAX_PATTERN_LENGTH_DEF = 16;
	localparam int POSITION_WIDTH_DEF     = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_PAT_LOW  = 2'd0;
	localparam cfg_idx_t REG_PAT_HIGH = 2'd1;
	localparam cfg_idx_t REG_PAT_LEN  = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_SEARCHING = 3'd0,
		ST_MATCH     = 3'd1,
		ST_ABSENT    = 3'd2,
		ST_OVERFLOW  = 3'd3,
		ST_DONE      = 3'd4
	} status_t;

	typedef logic [PAT_BYTES-1:0][TEXT_W-1:0] pattern_t;

endpackage

>>> rtl/core/sss_text_if.sv
// ----------------------------------------------------------------------------
// sss_text_if
// Text channel: one text byte per beat.
// ----------------------------------------------------------------------------
interface sss_text_if;
	logic                      valid;
	logic                      ready;
	logic [sss_pkg::TEXT_W-1:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink   (input valid, input text_byte, output ready);
endinterface

>>> rtl/core/sss_result_if.sv
// ----------------------------------------------------------------------------
// sss_result_if
// Result channel: status code and match position, one beat per text byte.
// ----------------------------------------------------------------------------
interface sss_result_if;
	logic                           valid;
	logic                           ready;
	logic [sss_pkg::STATUS_W-1:0]    status;
	logic [sss_pkg::MATCH_POS_W-1:0] match_position;

	modport source (output valid, output status, output match_position, input ready);
	modport sink   (input valid, input status, input match_position, output ready);
endinterface

>>> rtl/core/sss_cell.sv
// ----------------------------------------------------------------------------
// sss_cell
// One window cell: holds one text byte, passes it on when the window shifts,
// and checks the byte it is about to hold against its pattern byte.
// ----------------------------------------------------------------------------
module sss_cell #(
	parameter int IDX   = 0,
	parameter int LEN_W = 5
) (
	input  logic                        clk,
	input  logic                        shift,
	input  logic [sss_pkg::TEXT_W-1:0]  d_in,
	input  sss_pkg::pattern_t           pat,
	input  logic [LEN_W-1:0]            len,
	output logic [sss_pkg::TEXT_W-1:0]  d_q,
	output logic                        ok
);
	import sss_pkg::*;

	logic [4:0] sel;

	// cell IDX sees the byte that is IDX places back from the newest one,
	// which lines up with pattern byte len-1-IDX
	assign sel = 5'(len) - 5'(IDX + 1);
	assign ok  = (5'(len) <= 5'(IDX)) || (d_in == pat[sel[3:0]]);

	always_ff @(posedge clk) begin
		if (shift) begin
			d_q <= d_in;
		end
	end

endmodule

>>> rtl/core/sss_chain.sv
// ----------------------------------------------------------------------------
// sss_chain
// Row of window cells; the newest byte enters cell 0 and each cell hands its
// byte to the next on every shift. Reports whether all active cells agree.
// ----------------------------------------------------------------------------
module sss_chain #(
	parameter int WIN   = 16,
	parameter int LEN_W = 5
) (
	input  logic                        clk,
	input  logic                        shift,
	input  logic [sss_pkg::TEXT_W-1:0]  byte_in,
	input  sss_pkg::pattern_t           pat,
	input  logic [LEN_W-1:0]            len,
	output logic                        all_ok
);
	import sss_pkg::*;

	logic [WIN-1:0][TEXT_W-1:0] data;
	logic [WIN-1:0]             ok;

	for (genvar k = 0; k < WIN; k++) begin : g_cell
		logic [TEXT_W-1:0] d_in;
		if (k == 0) begin : g_head
			assign d_in = byte_in;
		end else begin : g_link
			assign d_in = data[k-1];
		end

		sss_cell #(
			.IDX   (k),
			.LEN_W (LEN_W)
		) u_cell (
			.clk   (clk),
			.shift (shift),
			.d_in  (d_in),
			.pat   (pat),
			.len   (len),
			.d_q   (data[k]),
			.ok    (ok[k])
		);
	end

	assign all_ok = &ok;

endmodule

>>> rtl/core/substring_search_stream.sv
// ----------------------------------------------------------------------------
// substring_search_stream
// First-occurrence search of a configured pattern in zero-terminated text
// that streams in one byte per beat.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                         | beat
//  text     | in  | text_byte[7:0]                  | one text byte
//  result   | out | status[2:0], match_position[15:0] | one per text byte
//  cfg      | in  | cfg_we, cfg_index[1:0], cfg_wdata[63:0] | one register write
//
// One text beat per cycle while text.ready is high; its result is registered and shows in the next cycle.
// The window shift and the parallel compare across the cell row set the cycle.
// Reset clears the pattern registers, the position counter and the fill count.
// text.ready drops only while a result is held and result.ready is low.
// ----------------------------------------------------------------------------
module substring_search_stream #(
	parameter int MAX_PATTERN_LENGTH = sss_pkg::MAX_PATTERN_LENGTH_DEF,
	parameter int POSITION_WIDTH     = sss_pkg::POSITION_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sss_text_if.sink                      text,
	sss_result_if.source                  result,
	input  logic                          cfg_we,
	input  logic [sss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sss_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import sss_pkg::*;

	localparam int WIN      = MAX_PATTERN_LENGTH;
	localparam int LEN_W    = $clog2(WIN + 1);
	localparam int POS_BITS = (POSITION_WIDTH > MATCH_POS_W) ? MATCH_POS_W : POSITION_WIDTH;

	logic [CFG_DATA_W-1:0]    pat_lo_q, pat_hi_q;
	logic [PAT_LEN_REG_W-1:0] pat_len_q;
	pattern_t                 pat;

	logic [POS_BITS-1:0] ti_q;
	logic [LEN_W-1:0]    cnt_q;
	logic                finished_q;

	logic                   res_valid_q;
	status_t                status_q;
	logic [MATCH_POS_W-1:0] pos_q;

	logic [LEN_W-1:0]    n_sat, eff_len, cnt_nxt;
	logic                accept, byte_zero, shift, all_ok, hit, at_end;
	status_t             status_d;
	logic [POS_BITS-1:0] pos_d;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAT_LOW:  pat_lo_q  <= cfg_wdata;
				REG_PAT_HIGH: pat_hi_q  <= cfg_wdata;
				REG_PAT_LEN:  pat_len_q <= cfg_wdata[PAT_LEN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	assign pat = {pat_hi_q, pat_lo_q};

	// effective length: saturate, then cut at the first zero byte
	always_comb begin
		int k;
		n_sat   = (pat_len_q > PAT_LEN_REG_W'(WIN)) ? LEN_W'(WIN) : LEN_W'(pat_len_q);
		eff_len = n_sat;
		for (k = WIN - 1; k >= 0; k--) begin
			if ((LEN_W'(k) < n_sat) && (pat[k] == '0)) begin
				eff_len = LEN_W'(k);
			end
		end
	end

	assign accept    = text.valid && text.ready;
	assign byte_zero = (text.text_byte == '0);
	assign shift     = accept && !finished_q && (eff_len != '0) && !byte_zero;

	sss_chain #(
		.WIN   (WIN),
		.LEN_W (LEN_W)
	) u_chain (
		.clk     (clk),
		.shift   (shift),
		.byte_in (text.text_byte),
		.pat     (pat),
		.len     (eff_len),
		.all_ok  (all_ok)
	);

	assign cnt_nxt = (cnt_q == LEN_W'(WIN)) ? cnt_q : cnt_q + LEN_W'(1);
	assign hit     = all_ok && (cnt_nxt >= eff_len);
	assign at_end  = (ti_q == '1);

	always_comb begin
		status_d = ST_SEARCHING;
		pos_d    = '0;
		if (finished_q) begin
			status_d = ST_DONE;
		end else if (eff_len == '0) begin
			status_d = ST_MATCH;
			pos_d    = ti_q;
		end else if (byte_zero) begin
			status_d = ST_ABSENT;
		end else if (hit) begin
			status_d = ST_MATCH;
			pos_d    = ti_q + POS_BITS'(1) - POS_BITS'(eff_len);
		end else if (at_end) begin
			status_d = ST_OVERFLOW;
		end
	end

	// search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ti_q       <= '0;
			cnt_q      <= '0;
			finished_q <= 1'b0;
		end else if (accept) begin
			if (byte_zero) begin
				ti_q       <= '0;
				cnt_q      <= '0;
				finished_q <= 1'b0;
			end else if (!finished_q) begin
				if (eff_len == '0) begin
					finished_q <= 1'b1;
				end else begin
					cnt_q <= cnt_nxt;
					if (hit || at_end) begin
						finished_q <= 1'b1;
					end else begin
						ti_q <= ti_q + POS_BITS'(1);
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			pos_q    <= MATCH_POS_W'(pos_d);
		end
	end

	assign text.ready            = !res_valid_q || result.ready;
	assign result.valid          = res_valid_q;
	assign result.status         = status_q;
	assign result.match_position = pos_q;

endmodule

>>> rtl/core/sss_checker.sv
// ----------------------------------------------------------------------------
// sss_checker
// Port-level checks for the substring search, bound to the top level.
// ----------------------------------------------------------------------------
module sss_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            text_valid,
	input logic                            text_ready,
	input logic                            res_valid,
	input logic                            res_ready,
	input logic [sss_pkg::STATUS_W-1:0]    res_status,
	input logic [sss_pkg::MATCH_POS_W-1:0] res_pos
);
	import sss_pkg::*;

	// a held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_pos))
		else $error("result changed while stalled");

	// every text beat yields a result on the next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text_ready |=> res_valid)
		else $error("text beat without result");

	// backpressure only comes from a waiting result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!text_ready |-> res_valid && !res_ready)
		else $error("text stalled without cause");

	// position is zero unless the beat reports a match
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status != ST_MATCH) |-> (res_pos == '0))
		else $error("position set on non-match beat");

endmodule

bind substring_search_stream sss_checker u_sss_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.text_valid (text.valid),
	.text_ready (text.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_status (result.status),
	.res_pos    (result.match_position)
);
